// ----- design/assert_macros.svh -----
// Assertion macros for the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define LSPS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same, on the default clk_i and rst_ni of the enclosing module.
`define LSPS_ASSERT_DEF(label, prop, msg) \
  `LSPS_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

// ----- design/lsps_pkg.sv -----
// Package: constants, codes and types of the line sensor position setpoint block.
`default_nettype none

package lsps_pkg;

  localparam int N_SENS              = 8;
  localparam int SIDE_SENS           = 4;
  localparam int DEFAULT_SAMPLE_BITS = 12;
  localparam int SET_W               = 14;
  localparam int POS_W               = 11;
  localparam int POS_MAX             = 896;
  localparam int CNT_W               = 3;
  localparam int QUOT_W              = POS_W - 1;
  localparam int FRAC_SHIFT          = 7;
  localparam int GAIN_SHIFT          = 8;
  localparam int CFG_IDX_W           = 3;
  localparam int CFG_DATA_W          = 16;
  localparam int QUEUE_DEPTH         = 2;

  localparam int ZERO_LEVEL_RST       = 800;
  localparam int BLACK_LEVEL_RST      = 1800;
  localparam int ACTIVE_LEVEL_RST     = 659;
  localparam int BASE_SETPOINT_RST    = 2048;
  localparam int STEER_GAIN_RST       = 1536;
  localparam int SETPOINT_FLOOR_RST   = 3840;
  localparam int SETPOINT_CEILING_RST = 8960;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_LEVEL       = 3'd0,
    REG_BLACK_LEVEL      = 3'd1,
    REG_ACTIVE_LEVEL     = 3'd2,
    REG_BASE_SETPOINT    = 3'd3,
    REG_STEER_GAIN       = 3'd4,
    REG_SETPOINT_FLOOR   = 3'd5,
    REG_SETPOINT_CEILING = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_FULL     = 2'd0,
    MODE_TURN     = 2'd1,
    MODE_STRAIGHT = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [CNT_W-1:0]   left_cnt;
    logic [CNT_W-1:0]   right_cnt;
  } frame_tag_t;

  // Sensor weight in half units: 2i - 7, leftmost sensor most negative.
  function automatic int sensor_weight(input int idx);
    return 2 * idx - (N_SENS - 1);
  endfunction

endpackage

`default_nettype wire

// ----- design/lsps_if.sv -----
// Interfaces: sample request channel, result channel and register write channel.
`default_nettype none

interface lsps_sample_if import lsps_pkg::*; #(
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_0;
  logic [SAMPLE_BITS-1:0] sample_1;
  logic [SAMPLE_BITS-1:0] sample_2;
  logic [SAMPLE_BITS-1:0] sample_3;
  logic [SAMPLE_BITS-1:0] sample_4;
  logic [SAMPLE_BITS-1:0] sample_5;
  logic [SAMPLE_BITS-1:0] sample_6;
  logic [SAMPLE_BITS-1:0] sample_7;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7,
    input  ready
  );
  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7,
    output ready
  );
endinterface

interface lsps_result_if import lsps_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] line_position;
  logic [SET_W-1:0]        left_setpoint;
  logic [SET_W-1:0]        right_setpoint;
  logic [CNT_W-1:0]        left_black_count;
  logic [CNT_W-1:0]        right_black_count;
  logic [1:0]              position_mode;

  modport source (
    output valid, line_position, left_setpoint, right_setpoint,
           left_black_count, right_black_count, position_mode,
    input  ready
  );
  modport sink (
    input  valid, line_position, left_setpoint, right_setpoint,
           left_black_count, right_black_count, position_mode,
    output ready
  );
endinterface

interface lsps_cfg_if import lsps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/lsps_cfg.sv -----
// Configuration register file: thresholds, base setpoint, gain and clamp limits.
`default_nettype none

module lsps_cfg import lsps_pkg::*; #(
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  lsps_cfg_if.sink               cfg_i,
  output logic [SAMPLE_BITS-1:0] zero_level_o,
  output logic [SAMPLE_BITS-1:0] black_level_o,
  output logic [SAMPLE_BITS-1:0] active_level_o,
  output logic [SET_W-1:0]       base_setpoint_o,
  output logic [SET_W-1:0]       steer_gain_o,
  output logic [SET_W-1:0]       setpoint_floor_o,
  output logic [SET_W-1:0]       setpoint_ceiling_o
);

  logic [SAMPLE_BITS-1:0] zero_q, black_q, active_q;
  logic [SET_W-1:0]       base_q, gain_q, floor_q, ceil_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q   <= SAMPLE_BITS'(ZERO_LEVEL_RST);
      black_q  <= SAMPLE_BITS'(BLACK_LEVEL_RST);
      active_q <= SAMPLE_BITS'(ACTIVE_LEVEL_RST);
      base_q   <= SET_W'(BASE_SETPOINT_RST);
      gain_q   <= SET_W'(STEER_GAIN_RST);
      floor_q  <= SET_W'(SETPOINT_FLOOR_RST);
      ceil_q   <= SET_W'(SETPOINT_CEILING_RST);
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_ZERO_LEVEL:       zero_q   <= cfg_i.data[SAMPLE_BITS-1:0];
        REG_BLACK_LEVEL:      black_q  <= cfg_i.data[SAMPLE_BITS-1:0];
        REG_ACTIVE_LEVEL:     active_q <= cfg_i.data[SAMPLE_BITS-1:0];
        REG_BASE_SETPOINT:    base_q   <= cfg_i.data[SET_W-1:0];
        REG_STEER_GAIN:       gain_q   <= cfg_i.data[SET_W-1:0];
        REG_SETPOINT_FLOOR:   floor_q  <= cfg_i.data[SET_W-1:0];
        REG_SETPOINT_CEILING: ceil_q   <= cfg_i.data[SET_W-1:0];
        default: ;
      endcase
    end
  end

  assign zero_level_o       = zero_q;
  assign black_level_o      = black_q;
  assign active_level_o     = active_q;
  assign base_setpoint_o    = base_q;
  assign steer_gain_o       = gain_q;
  assign setpoint_floor_o   = floor_q;
  assign setpoint_ceiling_o = ceil_q;

endmodule

`default_nettype wire

// ----- design/lsps_front.sv -----
// Front end: takes a sample request, forms strengths and side counts, picks the centroid sums.
`default_nettype none

module lsps_front import lsps_pkg::*; #(
  parameter  int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
  localparam int NUM_W       = SAMPLE_BITS + 5,
  localparam int DEN_W       = SAMPLE_BITS + 3,
  localparam int ITEM_W      = $bits(frame_tag_t) + NUM_W + DEN_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  lsps_sample_if.sink            in_i,
  input  logic [SAMPLE_BITS-1:0] zero_level_i,
  input  logic [SAMPLE_BITS-1:0] black_level_i,
  input  logic [SAMPLE_BITS-1:0] active_level_i,
  output logic                   push_o,
  output logic [ITEM_W-1:0]      item_o,
  input  logic                   full_i
);

  logic [SAMPLE_BITS-1:0] samples [N_SENS];
  logic                   fe;

  // Stage A: strengths, active flags, black counts
  logic [SAMPLE_BITS-1:0] str_d [N_SENS];
  logic [SAMPLE_BITS-1:0] str_q [N_SENS];
  logic [N_SENS-1:0]      act_d, act_q;
  logic [CNT_W-1:0]       lb_d, rb_d, lb_q, rb_q;
  logic                   a_vld_q;

  // Stage B: weighted sums and side classification
  logic signed [NUM_W-1:0] num_full_d, num_act_d, num_full_q, num_act_q;
  logic [DEN_W-1:0]        den_full_d, den_act_d, den_full_q, den_act_q;
  logic                    turn_d, straight_d, turn_q, straight_q;
  logic [CNT_W-1:0]        lb_b_q, rb_b_q;
  logic                    b_vld_q;

  logic signed [NUM_W-1:0] sel_num;
  logic [DEN_W-1:0]        sel_den;
  frame_tag_t              sel_tag;

  assign samples[0] = in_i.sample_0;
  assign samples[1] = in_i.sample_1;
  assign samples[2] = in_i.sample_2;
  assign samples[3] = in_i.sample_3;
  assign samples[4] = in_i.sample_4;
  assign samples[5] = in_i.sample_5;
  assign samples[6] = in_i.sample_6;
  assign samples[7] = in_i.sample_7;

  // The whole front advances unless a finished frame waits on a full queue.
  assign fe         = !b_vld_q || !full_i;
  assign in_i.ready = fe;
  assign push_o     = b_vld_q && !full_i;

  always_comb begin
    lb_d = '0;
    rb_d = '0;
    for (int i = 0; i < N_SENS; i++) begin
      str_d[i] = (samples[i] > zero_level_i) ? samples[i] - zero_level_i : '0;
      act_d[i] = str_d[i] > active_level_i;
      if (i < SIDE_SENS) begin
        lb_d = lb_d + CNT_W'(samples[i] > black_level_i);
      end else begin
        rb_d = rb_d + CNT_W'(samples[i] > black_level_i);
      end
    end
  end

  always_comb begin
    num_full_d = '0;
    num_act_d  = '0;
    den_full_d = '0;
    den_act_d  = '0;
    for (int i = 0; i < N_SENS; i++) begin
      num_full_d = num_full_d
                 + $signed(NUM_W'(sensor_weight(i))) * $signed(NUM_W'(str_q[i]));
      den_full_d = den_full_d + DEN_W'(str_q[i]);
      if (act_q[i]) begin
        num_act_d = num_act_d
                  + $signed(NUM_W'(sensor_weight(i))) * $signed(NUM_W'(str_q[i]));
        den_act_d = den_act_d + DEN_W'(str_q[i]);
      end
    end
    turn_d     = (lb_q == CNT_W'(1) && rb_q == '0) || (rb_q == CNT_W'(1) && lb_q == '0);
    straight_d = (lb_q == CNT_W'(1) && rb_q >= CNT_W'(2))
              || (rb_q == CNT_W'(1) && lb_q >= CNT_W'(2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (fe) begin
      a_vld_q <= in_i.valid;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fe) begin
      str_q      <= str_d;
      act_q      <= act_d;
      lb_q       <= lb_d;
      rb_q       <= rb_d;
      num_full_q <= num_full_d;
      num_act_q  <= num_act_d;
      den_full_q <= den_full_d;
      den_act_q  <= den_act_d;
      turn_q     <= turn_d;
      straight_q <= straight_d;
      lb_b_q     <= lb_q;
      rb_b_q     <= rb_q;
    end
  end

  // Forced straight goes down as 0/0, which the divider turns into position 0.
  always_comb begin
    sel_tag.left_cnt  = lb_b_q;
    sel_tag.right_cnt = rb_b_q;
    if (straight_q) begin
      sel_num      = '0;
      sel_den      = '0;
      sel_tag.mode = MODE_STRAIGHT;
    end else if (turn_q && den_act_q != '0) begin
      sel_num      = num_act_q;
      sel_den      = den_act_q;
      sel_tag.mode = MODE_TURN;
    end else begin
      sel_num      = num_full_q;
      sel_den      = den_full_q;
      sel_tag.mode = MODE_FULL;
    end
  end

  assign item_o = {sel_tag, sel_num, sel_den};

endmodule

`default_nettype wire

// ----- design/lsps_queue.sv -----
// Short queue between the front end and the back end.
`default_nettype none

module lsps_queue import lsps_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             avail_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign avail_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/lsps_back.sv -----
// Back end: pipelined centroid divider, steering multiply, setpoint clamp, result register.
`default_nettype none

module lsps_back import lsps_pkg::*; #(
  parameter  int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
  localparam int NUM_W       = SAMPLE_BITS + 5,
  localparam int DEN_W       = SAMPLE_BITS + 3,
  localparam int ITEM_W      = $bits(frame_tag_t) + NUM_W + DEN_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  logic [ITEM_W-1:0] item_i,
  output logic              pop_o,
  input  logic [SET_W-1:0]  base_setpoint_i,
  input  logic [SET_W-1:0]  steer_gain_i,
  input  logic [SET_W-1:0]  setpoint_floor_i,
  input  logic [SET_W-1:0]  setpoint_ceiling_i,
  lsps_result_if.source     out_o
);

  localparam int DIV_W  = NUM_W + FRAC_SHIFT - 1;
  localparam int CMP_W  = DEN_W + QUOT_W - 1;
  localparam int PROD_W = SET_W + 1 + POS_W;
  localparam int SUM_W  = SET_W + 4;

  logic be;

  // Queue head
  frame_tag_t              head_tag;
  logic signed [NUM_W-1:0] head_num;
  logic [DEN_W-1:0]        head_den;
  logic [NUM_W-1:0]        head_mag;

  // Divider stages, one quotient bit each
  logic [DIV_W-1:0]  rem_in [QUOT_W];
  logic [DEN_W-1:0]  den_in [QUOT_W];
  logic [QUOT_W-1:0] quo_in [QUOT_W];
  logic              neg_in [QUOT_W];
  logic              zero_in [QUOT_W];
  frame_tag_t        tag_in [QUOT_W];
  logic [DIV_W-1:0]  rem_q [QUOT_W];
  logic [DEN_W-1:0]  den_q [QUOT_W];
  logic [QUOT_W-1:0] quo_q [QUOT_W];
  logic              neg_q [QUOT_W];
  logic              zero_q [QUOT_W];
  frame_tag_t        tag_q [QUOT_W];
  logic [QUOT_W-1:0] div_vld_q;

  // Position, product and result stages
  logic signed [POS_W-1:0]  pos_mag, pos_d, pos_q, mpos_q;
  frame_tag_t               ptag_q, mtag_q;
  logic                     pos_vld_q, mul_vld_q, out_vld_q;
  logic signed [PROD_W-1:0] prod_d, prod_q, prod_bias, prod_shr;
  logic signed [SUM_W-1:0]  offset, base_s, floor_s, ceil_s, left_v, right_v;

  logic signed [POS_W-1:0]  opos_q;
  logic [SET_W-1:0]         oleft_q, oright_q;
  frame_tag_t               otag_q;

  function automatic logic [SET_W-1:0] clamp_set(
    input logic signed [SUM_W-1:0] v,
    input logic signed [SUM_W-1:0] lo,
    input logic signed [SUM_W-1:0] hi
  );
    logic [SET_W-1:0] r;
    if (v < lo) begin
      r = SET_W'(lo);
    end else if (v > hi) begin
      r = SET_W'(hi);
    end else begin
      r = SET_W'(v);
    end
    return r;
  endfunction

  // The whole back end holds while a result waits to be taken.
  assign be    = !out_vld_q || out_o.ready;
  assign pop_o = be && avail_i;

  assign {head_tag, head_num, head_den} = item_i;
  assign head_mag = head_num[NUM_W-1] ? NUM_W'(-head_num) : NUM_W'(head_num);

  always_comb begin
    rem_in[0]  = DIV_W'(head_mag) << FRAC_SHIFT;
    den_in[0]  = head_den;
    quo_in[0]  = '0;
    neg_in[0]  = head_num[NUM_W-1];
    zero_in[0] = head_den == '0;
    tag_in[0]  = head_tag;
    for (int j = 1; j < QUOT_W; j++) begin
      rem_in[j]  = rem_q[j-1];
      den_in[j]  = den_q[j-1];
      quo_in[j]  = quo_q[j-1];
      neg_in[j]  = neg_q[j-1];
      zero_in[j] = zero_q[j-1];
      tag_in[j]  = tag_q[j-1];
    end
  end

  for (genvar j = 0; j < QUOT_W; j++) begin : g_div
    localparam int K = QUOT_W - 1 - j;
    logic [CMP_W-1:0] trial;
    logic             ge;

    assign trial = CMP_W'(den_in[j]) << K;
    assign ge    = CMP_W'(rem_in[j]) >= trial;

    always_ff @(posedge clk_i) begin
      if (be) begin
        rem_q[j]  <= ge ? DIV_W'(CMP_W'(rem_in[j]) - trial) : rem_in[j];
        quo_q[j]  <= quo_in[j] | ({{(QUOT_W-1){1'b0}}, ge} << K);
        den_q[j]  <= den_in[j];
        neg_q[j]  <= neg_in[j];
        zero_q[j] <= zero_in[j];
        tag_q[j]  <= tag_in[j];
      end
    end
  end

  // Apply the sign after the magnitude divide: truncates toward zero.
  always_comb begin
    pos_mag = $signed(POS_W'(quo_q[QUOT_W-1]));
    if (zero_q[QUOT_W-1]) begin
      pos_d = '0;
    end else if (neg_q[QUOT_W-1]) begin
      pos_d = -pos_mag;
    end else begin
      pos_d = pos_mag;
    end
  end

  assign prod_d = $signed({1'b0, steer_gain_i}) * pos_q;

  // Round the scaled product toward zero before the add.
  assign prod_bias = prod_q[PROD_W-1] ? PROD_W'((1 << GAIN_SHIFT) - 1) : '0;
  assign prod_shr  = (prod_q + prod_bias) >>> GAIN_SHIFT;
  assign offset    = SUM_W'(prod_shr);
  assign base_s    = $signed(SUM_W'(base_setpoint_i));
  assign floor_s   = $signed(SUM_W'(setpoint_floor_i));
  assign ceil_s    = $signed(SUM_W'(setpoint_ceiling_i));
  assign left_v    = base_s + offset;
  assign right_v   = base_s - offset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q <= '0;
      pos_vld_q <= 1'b0;
      mul_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (be) begin
      div_vld_q <= {div_vld_q[QUOT_W-2:0], avail_i};
      pos_vld_q <= div_vld_q[QUOT_W-1];
      mul_vld_q <= pos_vld_q;
      out_vld_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      pos_q    <= pos_d;
      ptag_q   <= tag_q[QUOT_W-1];
      prod_q   <= prod_d;
      mpos_q   <= pos_q;
      mtag_q   <= ptag_q;
      opos_q   <= mpos_q;
      oleft_q  <= clamp_set(left_v, floor_s, ceil_s);
      oright_q <= clamp_set(right_v, floor_s, ceil_s);
      otag_q   <= mtag_q;
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.line_position     = opos_q;
  assign out_o.left_setpoint     = oleft_q;
  assign out_o.right_setpoint    = oright_q;
  assign out_o.left_black_count  = otag_q.left_cnt;
  assign out_o.right_black_count = otag_q.right_cnt;
  assign out_o.position_mode     = otag_q.mode;

endmodule

`default_nettype wire

// ----- design/line_sensor_position_setpoint_core.sv -----
// Line sensor position and wheel setpoint core: top level.
//
// Takes one request of eight line-sensor samples per cycle while the input is ready, and
// returns, per request, the signed Q7 line position (strength-weighted centroid, or the
// active-sensor centroid when one side sees a single black sensor and the other none, or
// zero when one side sees one and the other two or more), the black counts per side, the
// position mode, and left and right wheel setpoints clamped to the floor and ceiling.
// Throughput is one request per cycle while nothing stalls; a result stays on the output
// until it is taken at an edge when the output is ready. Each request passes through two
// front-end stages, a two-entry queue, the ten-stage restoring divider that produces one
// quotient bit per stage, and the position, multiply and result stages. The front end and
// the back end stall separately, so the input keeps flowing while a result waits at the
// output, until the queue and both front-end stages are full.
// Configuration registers are written through the cfg channel, which is always ready;
// write them only while no request is in flight.
`default_nettype none

module line_sensor_position_setpoint_core import lsps_pkg::*; #(
  parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lsps_sample_if.sink   in_i,
  lsps_result_if.source out_o,
  lsps_cfg_if.sink      cfg_i
);

  localparam int NUM_W  = SAMPLE_BITS + 5;
  localparam int DEN_W  = SAMPLE_BITS + 3;
  localparam int ITEM_W = $bits(frame_tag_t) + NUM_W + DEN_W;

  logic [SAMPLE_BITS-1:0] zero_level, black_level, active_level;
  logic [SET_W-1:0]       base_setpoint, steer_gain, setpoint_floor, setpoint_ceiling;

  logic              q_push, q_full, q_pop, q_avail;
  logic [ITEM_W-1:0] q_wdata, q_rdata;

  lsps_cfg #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_cfg (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_i),
    .zero_level_o       (zero_level),
    .black_level_o      (black_level),
    .active_level_o     (active_level),
    .base_setpoint_o    (base_setpoint),
    .steer_gain_o       (steer_gain),
    .setpoint_floor_o   (setpoint_floor),
    .setpoint_ceiling_o (setpoint_ceiling)
  );

  lsps_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .zero_level_i   (zero_level),
    .black_level_i  (black_level),
    .active_level_i (active_level),
    .push_o         (q_push),
    .item_o         (q_wdata),
    .full_i         (q_full)
  );

  lsps_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .avail_o (q_avail),
    .data_o  (q_rdata)
  );

  lsps_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .avail_i            (q_avail),
    .item_i             (q_rdata),
    .pop_o              (q_pop),
    .base_setpoint_i    (base_setpoint),
    .steer_gain_i       (steer_gain),
    .setpoint_floor_i   (setpoint_floor),
    .setpoint_ceiling_i (setpoint_ceiling),
    .out_o              (out_o)
  );

endmodule

`default_nettype wire

// ----- design/lsps_checker.sv -----
// Port-level checker for the line sensor position setpoint core, with its bind.
`default_nettype none

`include "assert_macros.svh"

module lsps_checker import lsps_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [POS_W-1:0] line_position,
  input logic [SET_W-1:0]        left_setpoint,
  input logic [SET_W-1:0]        right_setpoint,
  input logic [CNT_W-1:0]        left_black_count,
  input logic [CNT_W-1:0]        right_black_count,
  input logic [1:0]              position_mode
);

  `LSPS_ASSERT_DEF(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  `LSPS_ASSERT_DEF(a_out_stable, out_valid && !out_ready |=> $stable(line_position) && $stable(left_setpoint) && $stable(right_setpoint) && $stable(position_mode), "result changed while stalled")

  `LSPS_ASSERT_DEF(a_straight_zero, out_valid && position_mode == MODE_STRAIGHT |-> line_position == '0 && left_setpoint == right_setpoint, "forced straight with nonzero steer")

  `LSPS_ASSERT_DEF(a_pos_range, out_valid |-> line_position >= -POS_MAX && line_position <= POS_MAX, "position out of range")

  `LSPS_ASSERT_DEF(a_mode_counts, out_valid && position_mode != MODE_FULL |-> left_black_count == CNT_W'(1) || right_black_count == CNT_W'(1), "turn or straight mode without a single black side")

endmodule

bind line_sensor_position_setpoint_core lsps_checker u_lsps_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid         (out_o.valid),
  .out_ready         (out_o.ready),
  .line_position     (out_o.line_position),
  .left_setpoint     (out_o.left_setpoint),
  .right_setpoint    (out_o.right_setpoint),
  .left_black_count  (out_o.left_black_count),
  .right_black_count (out_o.right_black_count),
  .position_mode     (out_o.position_mode)
);

`default_nettype wire

// ----- sim/line_sensor_position_setpoint_core_test.sv -----
// Testbench of the line sensor position setpoint core: directed and random frames checked against a predictor.
module line_sensor_position_setpoint_core_test import lsps_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_BITS  = DEFAULT_SAMPLE_BITS;
  localparam int MAX_SAMPLE   = (1 << SAMPLE_BITS) - 1;
  localparam int MAX_SET      = (1 << SET_W) - 1;
  localparam int CLK_PERIOD   = 10;
  localparam int SETTLE_TICKS = 24;
  localparam int HOLD_TICKS   = 300;
  localparam int TIMEOUT_NS   = 5_000_000;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [N_SENS-1:0][SAMPLE_BITS-1:0] frame_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [SET_W-1:0] left_set;
    logic [SET_W-1:0] right_set;
    logic [CNT_W-1:0] left_cnt;
    logic [CNT_W-1:0] right_cnt;
    mode_e            mode;
  } setpoint_result_t;

  logic clk_i;
  logic rst_ni;

  lsps_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
  lsps_result_if out_if ();
  lsps_cfg_if    cfg_if ();

  line_sensor_position_setpoint_core #(.SAMPLE_BITS(SAMPLE_BITS)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source),
    .cfg_i  (cfg_if.sink)
  );

  // Register copies used by the predictor
  sample_t          zero_lvl, black_lvl, active_lvl;
  logic [SET_W-1:0] base_set, steer_gain, set_floor, set_ceiling;

  frame_t           pending_frames[$];
  setpoint_result_t expected_setpoints[$];

  int   frames_sent;
  int   mismatch_cnt;
  int   hold_at;
  int   src_gap, sink_gap;
  int   src_idle_pct, sink_idle_pct;
  logic sink_hold;

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [SET_W-1:0] clamp_setpoint(input longint v);
    if (v < longint'(set_floor)) return set_floor;
    if (v > longint'(set_ceiling)) return set_ceiling;
    return v[SET_W-1:0];
  endfunction

  function automatic setpoint_result_t predict_setpoints(input frame_t f);
    longint           strength;
    longint           num_all, den_all, num_act, den_act, pos, offset;
    int               lcnt, rcnt;
    mode_e            mode;
    setpoint_result_t r;
    lcnt = 0;
    rcnt = 0;
    num_all = 0;
    den_all = 0;
    num_act = 0;
    den_act = 0;
    for (int i = 0; i < N_SENS; i++) begin
      strength = (f[i] > zero_lvl) ? longint'(f[i]) - longint'(zero_lvl) : 0;
      num_all += (2 * i - 7) * strength * 128;
      den_all += strength;
      if (strength > longint'(active_lvl)) begin
        num_act += (2 * i - 7) * strength * 128;
        den_act += strength;
      end
      if (f[i] > black_lvl) begin
        if (i < SIDE_SENS) lcnt++;
        else rcnt++;
      end
    end
    pos = (den_all > 0) ? num_all / den_all : 0;
    mode = MODE_FULL;
    // Single black on one side, none on the other: steer on active sensors only
    if (((lcnt == 1 && rcnt == 0) || (rcnt == 1 && lcnt == 0)) && den_act > 0) begin
      pos = num_act / den_act;
      mode = MODE_TURN;
    end
    if ((lcnt == 1 && rcnt >= 2) || (rcnt == 1 && lcnt >= 2)) begin
      pos = 0;
      mode = MODE_STRAIGHT;
    end
    offset = (longint'(steer_gain) * pos) / 256;
    r.position  = pos[POS_W-1:0];
    r.left_set  = clamp_setpoint(longint'(base_set) + offset);
    r.right_set = clamp_setpoint(longint'(base_set) - offset);
    r.left_cnt  = lcnt[CNT_W-1:0];
    r.right_cnt = rcnt[CNT_W-1:0];
    r.mode      = mode;
    return r;
  endfunction

  // Driver: offer the oldest pending frame, hold it until taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        expected_setpoints.push_back(predict_setpoints(pending_frames[0]));
        void'(pending_frames.pop_front());
        frames_sent++;
      end
      if (!(in_if.valid === 1'b1 && in_if.ready !== 1'b1)) begin
        if (src_gap > 0) begin
          src_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_frames.size() != 0 &&
                     $urandom_range(0, 99) < src_idle_pct) begin
          src_gap = $urandom_range(1, 10) - 1;
          in_if.valid <= 1'b0;
        end else if (pending_frames.size() != 0) begin
          in_if.valid    <= 1'b1;
          in_if.sample_0 <= pending_frames[0][0];
          in_if.sample_1 <= pending_frames[0][1];
          in_if.sample_2 <= pending_frames[0][2];
          in_if.sample_3 <= pending_frames[0][3];
          in_if.sample_4 <= pending_frames[0][4];
          in_if.sample_5 <= pending_frames[0][5];
          in_if.sample_6 <= pending_frames[0][6];
          in_if.sample_7 <= pending_frames[0][7];
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result with the oldest prediction
  always @(posedge clk_i) begin
    setpoint_result_t exp_r;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (expected_setpoints.size() == 0) begin
          $error("unexpected result: line_position %0d", $signed(out_if.line_position));
          mismatch_cnt++;
        end else begin
          exp_r = expected_setpoints.pop_front();
          if (out_if.line_position !== exp_r.position) begin
            $error("line_position: expected %0d, actual %0d",
                   $signed(exp_r.position), $signed(out_if.line_position));
            mismatch_cnt++;
          end
          if (out_if.left_setpoint !== exp_r.left_set) begin
            $error("left_setpoint: expected %0d, actual %0d",
                   exp_r.left_set, out_if.left_setpoint);
            mismatch_cnt++;
          end
          if (out_if.right_setpoint !== exp_r.right_set) begin
            $error("right_setpoint: expected %0d, actual %0d",
                   exp_r.right_set, out_if.right_setpoint);
            mismatch_cnt++;
          end
          if (out_if.left_black_count !== exp_r.left_cnt) begin
            $error("left_black_count: expected %0d, actual %0d",
                   exp_r.left_cnt, out_if.left_black_count);
            mismatch_cnt++;
          end
          if (out_if.right_black_count !== exp_r.right_cnt) begin
            $error("right_black_count: expected %0d, actual %0d",
                   exp_r.right_cnt, out_if.right_black_count);
            mismatch_cnt++;
          end
          if (out_if.position_mode !== exp_r.mode) begin
            $error("position_mode: expected %0d, actual %0d",
                   exp_r.mode, out_if.position_mode);
            mismatch_cnt++;
          end
        end
      end
      if (sink_hold) begin
        out_if.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < sink_idle_pct) begin
        sink_gap = $urandom_range(1, 10) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off so the pipeline fills and backs up the input
  initial begin
    wait (hold_at != 0 && frames_sent >= hold_at);
    @(posedge clk_i);
    sink_hold <= 1'b1;
    repeat (HOLD_TICKS) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("line_sensor_position_setpoint_core_test: FAIL");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] wdata);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= wdata;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    case (idx)
      REG_ZERO_LEVEL:       zero_lvl    = wdata[SAMPLE_BITS-1:0];
      REG_BLACK_LEVEL:      black_lvl   = wdata[SAMPLE_BITS-1:0];
      REG_ACTIVE_LEVEL:     active_lvl  = wdata[SAMPLE_BITS-1:0];
      REG_BASE_SETPOINT:    base_set    = wdata[SET_W-1:0];
      REG_STEER_GAIN:       steer_gain  = wdata[SET_W-1:0];
      REG_SETPOINT_FLOOR:   set_floor   = wdata[SET_W-1:0];
      REG_SETPOINT_CEILING: set_ceiling = wdata[SET_W-1:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  // Fill the bits above the register width with junk; the block must drop them
  function automatic logic [CFG_DATA_W-1:0] pad_junk(input int value, input int width);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    for (int b = 0; b < width; b++) d[b] = value[b];
    return d;
  endfunction

  task automatic apply_settings(input int zero, input int black, input int active,
                                input int base, input int gain,
                                input int floor_v, input int ceil_v);
    write_reg(REG_ZERO_LEVEL,       pad_junk(zero, SAMPLE_BITS));
    write_reg(REG_BLACK_LEVEL,      pad_junk(black, SAMPLE_BITS));
    write_reg(REG_ACTIVE_LEVEL,     pad_junk(active, SAMPLE_BITS));
    write_reg(REG_BASE_SETPOINT,    pad_junk(base, SET_W));
    write_reg(REG_STEER_GAIN,       pad_junk(gain, SET_W));
    write_reg(REG_SETPOINT_FLOOR,   pad_junk(floor_v, SET_W));
    write_reg(REG_SETPOINT_CEILING, pad_junk(ceil_v, SET_W));
  endtask

  task automatic random_settings();
    int zero;
    zero = $urandom_range(0, 1500);
    apply_settings(zero, $urandom_range(zero, 3500), $urandom_range(0, 2000),
                   $urandom_range(0, MAX_SET), $urandom_range(0, MAX_SET),
                   $urandom_range(0, 8000), $urandom_range(4000, MAX_SET));
  endtask

  task automatic queue_frame(input sample_t s0, input sample_t s1, input sample_t s2,
                             input sample_t s3, input sample_t s4, input sample_t s5,
                             input sample_t s6, input sample_t s7);
    pending_frames.push_back({s7, s6, s5, s4, s3, s2, s1, s0});
  endtask

  function automatic sample_t pick_sample(input bit black);
    if (!black) return sample_t'($urandom_range(0, black_lvl));
    if (black_lvl == MAX_SAMPLE) return sample_t'(MAX_SAMPLE);
    return sample_t'($urandom_range(black_lvl + 1, MAX_SAMPLE));
  endfunction

  function automatic logic [SIDE_SENS-1:0] pick_mask(input int ones);
    logic [SIDE_SENS-1:0] m;
    do m = SIDE_SENS'($urandom_range(0, (1 << SIDE_SENS) - 1)); while ($countones(m) != ones);
    return m;
  endfunction

  // Mostly frames shaped like a line under the sensors, some plain noise
  function automatic frame_t make_frame();
    frame_t f;
    int     kind, lcnt, rcnt, tmp;
    logic [N_SENS-1:0] blk;
    kind = $urandom_range(0, 9);
    lcnt = $urandom_range(0, SIDE_SENS);
    rcnt = $urandom_range(0, SIDE_SENS);
    if (kind <= 1) begin
      for (int i = 0; i < N_SENS; i++) begin
        case ($urandom_range(0, 7))
          0:       f[i] = '0;
          1:       f[i] = sample_t'(MAX_SAMPLE);
          default: f[i] = sample_t'($urandom_range(0, MAX_SAMPLE));
        endcase
      end
      return f;
    end
    if (kind <= 4) begin
      lcnt = 1;
      rcnt = 0;
    end else if (kind <= 6) begin
      lcnt = 1;
      rcnt = $urandom_range(2, SIDE_SENS);
    end
    if ($urandom_range(0, 1)) begin
      tmp = lcnt;
      lcnt = rcnt;
      rcnt = tmp;
    end
    blk = {pick_mask(rcnt), pick_mask(lcnt)};
    for (int i = 0; i < N_SENS; i++) f[i] = pick_sample(blk[i]);
    return f;
  endfunction

  // Wait for every request taken and every result back, then let the pipeline settle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_frames.size() != 0 || in_if.valid !== 1'b0 || expected_setpoints.size() != 0);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic run_random(input int n_frames, input int src_pct, input int sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int n = 0; n < n_frames; n++) pending_frames.push_back(make_frame());
    wait_idle();
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.sample_0 = '0;
    in_if.sample_1 = '0;
    in_if.sample_2 = '0;
    in_if.sample_3 = '0;
    in_if.sample_4 = '0;
    in_if.sample_5 = '0;
    in_if.sample_6 = '0;
    in_if.sample_7 = '0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    sink_hold      = 1'b0;
    frames_sent    = 0;
    mismatch_cnt   = 0;
    hold_at        = 0;
    src_gap        = 0;
    sink_gap       = 0;
    src_idle_pct   = 20;
    sink_idle_pct  = 20;
    zero_lvl       = sample_t'(ZERO_LEVEL_RST);
    black_lvl      = sample_t'(BLACK_LEVEL_RST);
    active_lvl     = sample_t'(ACTIVE_LEVEL_RST);
    base_set       = SET_W'(BASE_SETPOINT_RST);
    steer_gain     = SET_W'(STEER_GAIN_RST);
    set_floor      = SET_W'(SETPOINT_FLOOR_RST);
    set_ceiling    = SET_W'(SETPOINT_CEILING_RST);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Out-of-range index must leave every register alone
    write_reg(REG_NONE, '1);

    // Reset settings: zero frame, saturation, thresholds and each mode
    queue_frame(0, 0, 0, 0, 0, 0, 0, 0);
    queue_frame(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
    queue_frame(800, 800, 800, 800, 800, 800, 800, 800);
    queue_frame(4095, 0, 0, 0, 0, 0, 0, 0);
    queue_frame(0, 0, 0, 0, 0, 0, 0, 4095);
    queue_frame(0, 0, 0, 1801, 0, 0, 0, 0);
    queue_frame(0, 0, 0, 1800, 0, 0, 0, 0);
    queue_frame(0, 0, 0, 0, 1801, 1500, 1460, 0);
    queue_frame(4095, 0, 0, 0, 4095, 4095, 0, 0);
    queue_frame(4095, 4095, 4095, 4095, 0, 0, 0, 4095);
    queue_frame(4095, 4095, 0, 0, 0, 0, 4095, 4095);
    queue_frame(12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA, 12'h555, 12'h555, 12'h555, 12'h555);
    queue_frame(12'h555, 12'h555, 12'h555, 12'h555, 12'hAAA, 12'hAAA, 12'hAAA, 12'hAAA);
    queue_frame(801, 801, 801, 801, 801, 801, 801, 801);
    queue_frame(801, 0, 0, 0, 0, 0, 0, 0);
    run_random(300, 25, 25);

    random_settings();
    hold_at = frames_sent + 60;
    run_random(400, 15, 30);

    // Low thresholds, full gain and open clamp range
    apply_settings(0, 0, 0, 0, MAX_SET, 0, MAX_SET);
    queue_frame(0, 0, 0, 0, 0, 0, 0, 1);
    run_random(250, 0, 0);

    // Every threshold at the top: no strength, no black sensor
    apply_settings(MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, MAX_SET, MAX_SET, 0, MAX_SET);
    queue_frame(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
    run_random(150, 20, 20);

    // No sensor can be active, and the floor sits above the ceiling
    apply_settings(0, 2000, MAX_SAMPLE, 6000, 3000, 9000, 4000);
    queue_frame(0, 0, 0, 0, 0, 0, 0, 4095);
    queue_frame(4095, 0, 0, 0, 0, 0, 0, 0);
    run_random(250, 10, 15);

    random_settings();
    run_random(200, 30, 10);

    apply_settings(ZERO_LEVEL_RST, BLACK_LEVEL_RST, ACTIVE_LEVEL_RST, BASE_SETPOINT_RST,
                   STEER_GAIN_RST, SETPOINT_FLOOR_RST, SETPOINT_CEILING_RST);
    run_random(250, 0, 0);

    if (mismatch_cnt == 0) begin
      $display("line_sensor_position_setpoint_core_test: PASS");
    end else begin
      $display("line_sensor_position_setpoint_core_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/lsps_pkg.sv
design/lsps_if.sv
design/lsps_cfg.sv
design/lsps_front.sv
design/lsps_queue.sv
design/lsps_back.sv
design/line_sensor_position_setpoint_core.sv
design/lsps_checker.sv
sim/line_sensor_position_setpoint_core_test.sv
